// ----- src/rc4_pkg.sv -----
// Shared constants, state and command types for the RC4 keystream generator.
package rc4_pkg;

    localparam int KEY_MAX_DEF   = 256;
    localparam int MAX_BURST_DEF = 64;
    localparam int BYTE_W        = 8;
    localparam int COUNT_W       = 7;

    localparam logic REQ_STREAM = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_KSA_RD,
        ST_KSA_ACC,
        ST_KSA_WN,
        ST_KSA_WA,
        ST_PRGA_I,
        ST_PRGA_J,
        ST_PRGA_WI,
        ST_PRGA_WJ
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_KEY_BYTE,
        OP_STREAM_LOAD,
        OP_FILL,
        OP_KSA_RD,
        OP_KSA_ACC,
        OP_KSA_WN,
        OP_KSA_WA,
        OP_PRGA_I,
        OP_PRGA_J,
        OP_PRGA_WI,
        OP_PRGA_WJ
    } dp_op_t;

    typedef struct packed {
        logic n_last;
        logic rem_last;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- src/rc4_req_if.sv -----
// Request channel: key bytes and keystream requests.
interface rc4_req_if import rc4_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [BYTE_W-1:0]  key_byte;
    logic               key_byte_valid;
    logic               key_last;
    logic [COUNT_W-1:0] byte_count;

    modport source (
        output valid, req_type, key_byte, key_byte_valid, key_last, byte_count,
        input  ready
    );
    modport sink (
        input  valid, req_type, key_byte, key_byte_valid, key_last, byte_count,
        output ready
    );
endinterface

// ----- src/rc4_ks_if.sv -----
// Keystream channel: one keystream byte per transaction.
interface rc4_ks_if import rc4_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] stream_byte;
    logic              last_byte;

    modport source (
        output valid, stream_byte, last_byte,
        input  ready
    );
    modport sink (
        input  valid, stream_byte, last_byte,
        output ready
    );
endinterface

// ----- src/rc4_ctrl.sv -----
// Sequencer for key loading, key schedule and keystream output steps.
module rc4_ctrl import rc4_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    rc4_req_if.sink  req,
    input  dp_stat_t stat,
    output dp_op_t   op
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        req.ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    if (req.req_type == REQ_STREAM)
                    begin
                        op = OP_STREAM_LOAD;
                        if (req.byte_count != '0)
                        begin
                            state_next = ST_PRGA_I;
                        end
                    end
                    else
                    begin
                        op = OP_KEY_BYTE;
                        if (req.key_last)
                        begin
                            state_next = ST_FILL;
                        end
                    end
                end
            end
            ST_FILL:
            begin
                op = OP_FILL;
                if (stat.n_last)
                begin
                    state_next = ST_KSA_RD;
                end
            end
            ST_KSA_RD:
            begin
                op         = OP_KSA_RD;
                state_next = ST_KSA_ACC;
            end
            ST_KSA_ACC:
            begin
                op         = OP_KSA_ACC;
                state_next = ST_KSA_WN;
            end
            ST_KSA_WN:
            begin
                op         = OP_KSA_WN;
                state_next = ST_KSA_WA;
            end
            ST_KSA_WA:
            begin
                op         = OP_KSA_WA;
                state_next = stat.n_last ? ST_IDLE : ST_KSA_RD;
            end
            ST_PRGA_I:
            begin
                // hold until the output register is sure to be free at write-back
                if (stat.out_free)
                begin
                    op         = OP_PRGA_I;
                    state_next = ST_PRGA_J;
                end
            end
            ST_PRGA_J:
            begin
                op         = OP_PRGA_J;
                state_next = ST_PRGA_WI;
            end
            ST_PRGA_WI:
            begin
                op         = OP_PRGA_WI;
                state_next = ST_PRGA_WJ;
            end
            ST_PRGA_WJ:
            begin
                op         = OP_PRGA_WJ;
                state_next = stat.rem_last ? ST_IDLE : ST_PRGA_I;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/rc4_dp.sv -----
// Permutation and key memories, indices and output register.
module rc4_dp import rc4_pkg::*;
#(
    parameter int KEY_MAX   = KEY_MAX_DEF,
    parameter int MAX_BURST = MAX_BURST_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_op_t             op,
    input  logic [BYTE_W-1:0]  key_byte,
    input  logic               key_byte_valid,
    input  logic [COUNT_W-1:0] byte_count,
    output dp_stat_t           stat,
    rc4_ks_if.source           ks
);

    localparam int KAW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int KLW = $clog2(KEY_MAX + 1);
    localparam int CW  = $clog2(MAX_BURST + 1);
    localparam int PERM_DEPTH = 1 << BYTE_W;

    logic [BYTE_W-1:0] perm_mem [PERM_DEPTH];
    logic [BYTE_W-1:0] key_mem  [KEY_MAX];

    logic [BYTE_W-1:0] perm_q_reg;
    logic [BYTE_W-1:0] key_q_reg;
    logic              perm_we;
    logic [BYTE_W-1:0] perm_wa;
    logic [BYTE_W-1:0] perm_wd;
    logic [BYTE_W-1:0] perm_ra;
    logic              key_we;
    logic [KAW-1:0]    key_ra;

    logic              keyed_reg, keyed_next;
    logic [BYTE_W-1:0] i_reg, i_next;
    logic [BYTE_W-1:0] j_reg, j_next;
    logic [BYTE_W-1:0] n_reg, n_next;
    logic [BYTE_W-1:0] acc_reg, acc_next;
    logic [KAW-1:0]    kpos_reg, kpos_next;
    logic [KLW-1:0]    key_len_reg, key_len_next;
    logic [CW-1:0]     rem_reg, rem_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] a_reg, a_next;
    logic [BYTE_W-1:0] b_reg, b_next;
    logic [BYTE_W-1:0] t_reg, t_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;

    logic [BYTE_W-1:0] s_q;
    logic [BYTE_W-1:0] kb;
    logic [BYTE_W-1:0] acc_sum;
    logic [BYTE_W-1:0] i_inc;
    logic [BYTE_W-1:0] j_sum;
    logic [BYTE_W-1:0] ab_sum;
    logic [KLW-1:0]    kpos_inc;
    logic [CW-1:0]     count_sat;
    logic [BYTE_W-1:0] ks_val;

    // the table reads as all zero until the first key schedule fills it
    assign s_q       = perm_q_reg & {BYTE_W{keyed_reg}};
    assign kb        = (key_len_reg == '0) ? '0 : key_q_reg;
    assign acc_sum   = acc_reg + kb + s_q;
    assign i_inc     = i_reg + BYTE_W'(1);
    assign j_sum     = j_reg + s_q;
    assign ab_sum    = a_reg + s_q;
    assign kpos_inc  = KLW'(kpos_reg) + KLW'(1);
    assign count_sat = (byte_count > COUNT_W'(MAX_BURST)) ? CW'(MAX_BURST)
                                                           : byte_count[CW-1:0];

    // both writes of the swap land after the read of S[i+j]: forward them
    assign ks_val = (t_reg == j_reg) ? a_reg :
                    (t_reg == i_reg) ? b_reg : s_q;

    assign stat.n_last   = (n_reg == '1);
    assign stat.rem_last = (rem_reg == CW'(1));
    assign stat.out_free = !out_valid_reg || ks.ready;

    assign ks.valid       = out_valid_reg;
    assign ks.stream_byte = out_byte_reg;
    assign ks.last_byte   = out_last_reg;

    always_comb
    begin
        keyed_next     = keyed_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        n_next         = n_reg;
        acc_next       = acc_reg;
        kpos_next      = kpos_reg;
        key_len_next   = key_len_reg;
        rem_next       = rem_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        t_next         = t_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !ks.ready;
        perm_we        = 1'b0;
        perm_wa        = n_reg;
        perm_wd        = n_reg;
        perm_ra        = i_reg;
        key_we         = 1'b0;
        key_ra         = kpos_reg;
        case (op)
            OP_KEY_BYTE:
            begin
                // drop bytes past the key buffer depth
                if (key_byte_valid && (key_len_reg < KLW'(KEY_MAX)))
                begin
                    key_we       = 1'b1;
                    key_len_next = key_len_reg + KLW'(1);
                end
            end
            OP_STREAM_LOAD:
            begin
                rem_next = count_sat;
            end
            OP_FILL:
            begin
                perm_we    = 1'b1;
                n_next     = n_reg + BYTE_W'(1);
                keyed_next = 1'b1;
                i_next     = '0;
                j_next     = '0;
                acc_next   = '0;
                kpos_next  = '0;
            end
            OP_KSA_RD:
            begin
                perm_ra = n_reg;
            end
            OP_KSA_ACC:
            begin
                a_next   = s_q;
                acc_next = acc_sum;
                perm_ra  = acc_sum;
            end
            OP_KSA_WN:
            begin
                perm_we = 1'b1;
                perm_wd = s_q;
            end
            OP_KSA_WA:
            begin
                perm_we   = 1'b1;
                perm_wa   = acc_reg;
                perm_wd   = a_reg;
                n_next    = n_reg + BYTE_W'(1);
                kpos_next = (kpos_inc >= key_len_reg) ? '0 : kpos_inc[KAW-1:0];
                if (n_reg == '1)
                begin
                    key_len_next = '0;
                end
            end
            OP_PRGA_I:
            begin
                i_next  = i_inc;
                perm_ra = i_inc;
            end
            OP_PRGA_J:
            begin
                a_next  = s_q;
                j_next  = j_sum;
                perm_ra = j_sum;
            end
            OP_PRGA_WI:
            begin
                b_next  = s_q;
                perm_we = 1'b1;
                perm_wa = i_reg;
                perm_wd = s_q;
                t_next  = ab_sum;
                perm_ra = ab_sum;
            end
            OP_PRGA_WJ:
            begin
                perm_we        = 1'b1;
                perm_wa        = j_reg;
                perm_wd        = a_reg;
                out_valid_next = 1'b1;
                out_byte_next  = ks_val;
                out_last_next  = (rem_reg == CW'(1));
                rem_next       = rem_reg - CW'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (perm_we)
        begin
            perm_mem[perm_wa] <= perm_wd;
        end
        perm_q_reg <= perm_mem[perm_ra];
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_len_reg[KAW-1:0]] <= key_byte;
        end
        key_q_reg <= key_mem[key_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keyed_reg     <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            acc_reg       <= '0;
            kpos_reg      <= '0;
            key_len_reg   <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            keyed_reg     <= keyed_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            n_reg         <= n_next;
            acc_reg       <= acc_next;
            kpos_reg      <= kpos_next;
            key_len_reg   <= key_len_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        t_reg        <= t_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

endmodule

// ----- src/rc4_keystream_generator.sv -----
// Top level of the RC4 keystream generator.
//
//  channel | role   | payload                                              | transaction
//  req     | sink   | req_type, key_byte, key_byte_valid, key_last, count  | key byte or request
//  ks      | source | stream_byte, last_byte                               | one keystream byte
//
// The item with key_last fills the permutation memory with the identity and then
// runs 256 swap steps of the key schedule, with the request channel held off.
// Each keystream byte is built in the steps PRGA_I, PRGA_J, PRGA_WI and PRGA_WJ in
// turn, as the permutation memory has a single read and write port; the next byte
// starts only once the byte in the output register is free or being taken.
// Reset clears indices, key length and the output valid; the table reads as zero.
module rc4_keystream_generator import rc4_pkg::*;
#(
    parameter int KEY_MAX   = KEY_MAX_DEF,
    parameter int MAX_BURST = MAX_BURST_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    rc4_req_if.sink   req,
    rc4_ks_if.source  ks
);

    dp_op_t   op;
    dp_stat_t stat;

    rc4_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .stat  (stat),
        .op    (op)
    );

    rc4_dp #(
        .KEY_MAX   (KEY_MAX),
        .MAX_BURST (MAX_BURST)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .op             (op),
        .key_byte       (req.key_byte),
        .key_byte_valid (req.key_byte_valid),
        .byte_count     (req.byte_count),
        .stat           (stat),
        .ks             (ks)
    );

endmodule

// ----- tb/rc4_keystream_generator_test.sv -----
// Self-checking testbench for the RC4 keystream generator: keys, keystream runs and flow control.
`timescale 1ns / 1ps

module rc4_keystream_generator_test;
    import rc4_pkg::*;

    localparam logic REQ_KEY       = ~REQ_STREAM;
    localparam int   CYCLE_LIMIT   = 1000000;
    localparam int   SETTLE_CYCLES = 1500;
    localparam int   MAX_REPORTS   = 10;
    localparam int   RANDOM_ITEMS  = 48;

    typedef struct packed {
        logic               req_type;
        logic [BYTE_W-1:0]  key_byte;
        logic               key_byte_valid;
        logic               key_last;
        logic [COUNT_W-1:0] byte_count;
    } rc4_req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] stream_byte;
        logic              last_byte;
    } ks_byte_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    rc4_req_if req();
    rc4_ks_if  ks();

    rc4_keystream_generator u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .ks    (ks)
    );

    // Predicted generator state
    logic [BYTE_W-1:0] perm [256];
    logic [BYTE_W-1:0] key_buf [256];
    logic [BYTE_W-1:0] idx_i = '0;
    logic [BYTE_W-1:0] idx_j = '0;
    int                key_len = 0;

    ks_byte_t pending_ks [$];

    int idle_pct     = 0;
    int stall_pct    = 0;
    int mismatches   = 0;
    int cycle_count  = 0;
    int random_items = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        ks.ready    <= ($urandom_range(99) >= stall_pct);
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL rc4_keystream_generator");
            $finish;
        end
    end

    function automatic void schedule_key();
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] t;
        logic [BYTE_W-1:0] kb;
        int                kpos;
        acc  = '0;
        kpos = 0;
        for (int n = 0; n < 256; n++)
            perm[n] = 8'(n);
        idx_i = '0;
        idx_j = '0;
        // An empty key acts as a single zero byte
        for (int n = 0; n < 256; n++)
        begin
            t       = perm[n];
            kb      = (key_len == 0) ? 8'h00 : key_buf[kpos];
            acc     = acc + kb + t;
            perm[n] = perm[acc];
            perm[acc] = t;
            kpos++;
            if (kpos >= key_len)
                kpos = 0;
        end
        key_len = 0;
    endfunction

    function automatic void apply_request(input rc4_req_t item);
        int                count;
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] b;
        ks_byte_t          want;
        if (item.req_type == REQ_KEY)
        begin
            // Drop bytes beyond the key buffer
            if (item.key_byte_valid && key_len < KEY_MAX_DEF)
            begin
                key_buf[key_len] = item.key_byte;
                key_len++;
            end
            if (item.key_last)
                schedule_key();
        end
        else
        begin
            count = (item.byte_count > MAX_BURST_DEF) ? MAX_BURST_DEF
                                                      : int'(item.byte_count);
            for (int n = 0; n < count; n++)
            begin
                idx_i       = idx_i + 8'd1;
                a           = perm[idx_i];
                idx_j       = idx_j + a;
                b           = perm[idx_j];
                perm[idx_i] = b;
                perm[idx_j] = a;
                want.stream_byte = perm[8'(a + b)];
                want.last_byte   = (n == count - 1);
                pending_ks.push_back(want);
            end
        end
    endfunction

    function automatic void note_failure(input string msg);
        if (mismatches < MAX_REPORTS)
            $display("[%0d] %s", cycle_count, msg);
        mismatches++;
    endfunction

    always @(posedge clk)
    begin
        ks_byte_t want;
        if (rst_n && ks.valid && ks.ready)
        begin
            if (pending_ks.size() == 0)
                note_failure($sformatf("unexpected keystream byte %02h last %0b",
                                       ks.stream_byte, ks.last_byte));
            else
            begin
                want = pending_ks.pop_front();
                if (ks.stream_byte !== want.stream_byte || ks.last_byte !== want.last_byte)
                    note_failure($sformatf(
                        "keystream mismatch: expected %02h last %0b, got %02h last %0b",
                        want.stream_byte, want.last_byte,
                        ks.stream_byte, ks.last_byte));
            end
        end
    end

    function automatic rc4_req_t key_item(input logic [BYTE_W-1:0] kb, input logic kv,
                                          input logic kl);
        rc4_req_t item;
        item.req_type       = REQ_KEY;
        item.key_byte       = kb;
        item.key_byte_valid = kv;
        item.key_last       = kl;
        item.byte_count     = COUNT_W'($urandom);
        return item;
    endfunction

    function automatic rc4_req_t stream_item(input logic [COUNT_W-1:0] count);
        rc4_req_t item;
        item.req_type       = REQ_STREAM;
        item.key_byte       = BYTE_W'($urandom);
        item.key_byte_valid = 1'($urandom_range(1));
        item.key_last       = 1'($urandom_range(1));
        item.byte_count     = count;
        return item;
    endfunction

    // Hold valid high from one transaction to the next unless the sender idles
    task automatic send_item(input rc4_req_t item);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid          <= 1'b1;
        req.req_type       <= item.req_type;
        req.key_byte       <= item.key_byte;
        req.key_byte_valid <= item.key_byte_valid;
        req.key_last       <= item.key_last;
        req.byte_count     <= item.byte_count;
        do
            @(posedge clk);
        while (!req.ready);
        apply_request(item);
    endtask

    task automatic wait_drain();
        req.valid <= 1'b0;
        while (pending_ks.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_stream_after_reset();
        // Permutation is all zero after reset
        send_item(stream_item(7'd3));
        send_item(stream_item(7'd0));
    endtask

    task automatic test_directed_keys();
        send_item(key_item(8'hA5, 1'b0, 1'b1));
        send_item(stream_item(7'd4));
        send_item(key_item(8'hFF, 1'b1, 1'b1));
        send_item(stream_item(7'd64));
        send_item(key_item(8'h00, 1'b1, 1'b0));
        send_item(key_item(8'hFF, 1'b1, 1'b0));
        send_item(key_item(8'h3C, 1'b0, 1'b0));
        send_item(key_item(8'h5A, 1'b1, 1'b0));
        send_item(key_item(8'hC3, 1'b0, 1'b1));
        send_item(stream_item(7'd127));
        send_item(stream_item(7'd65));
        send_item(stream_item(7'd0));
        send_item(stream_item(7'd1));
        send_item(key_item(8'h00, 1'b1, 1'b1));
        send_item(stream_item(7'd2));
        send_item(key_item(8'h80, 1'b1, 1'b0));
        send_item(key_item(8'h01, 1'b1, 1'b1));
        send_item(stream_item(7'd33));
        wait_drain();
    endtask

    task automatic test_key_overflow();
        idle_pct  = 10;
        stall_pct = 10;
        for (int k = 0; k < 258; k++)
            send_item(key_item(BYTE_W'($urandom), 1'b1, k == 257));
        send_item(stream_item(7'd16));
        wait_drain();
    endtask

    task automatic test_sender_pause();
        idle_pct  = 0;
        stall_pct = 45;
        send_item(key_item(8'h42, 1'b1, 1'b1));
        send_item(stream_item(7'd20));
        wait_drain();
        send_item(stream_item(7'd20));
        wait_drain();
    endtask

    task automatic send_random_stream();
        int                 r;
        logic [COUNT_W-1:0] count;
        r = $urandom_range(99);
        if (r < 5)
            count = '0;
        else if (r < 12)
            count = COUNT_W'($urandom_range(127, 65));
        else if (r < 60)
            count = COUNT_W'($urandom_range(16, 1));
        else
            count = COUNT_W'($urandom_range(64, 1));
        send_item(stream_item(count));
        if (count != 0)
            random_items++;
    endtask

    task automatic send_random_sequence();
        int r;
        int len;
        r = $urandom_range(99);
        if (r < 70)
        begin
            len = ($urandom_range(3) == 0) ? $urandom_range(48, 17)
                                           : $urandom_range(16, 1);
            for (int k = 0; k < len; k++)
                send_item(key_item(BYTE_W'($urandom), $urandom_range(9) != 0,
                                   k == len - 1));
            random_items += len;
            repeat ($urandom_range(3, 1))
                send_random_stream();
        end
        else if (r < 85)
        begin
            // Unfinished key: bytes pile up for the next schedule
            len = $urandom_range(4, 1);
            for (int k = 0; k < len; k++)
                send_item(key_item(BYTE_W'($urandom), 1'($urandom_range(1)), 1'b0));
            random_items += len;
        end
        else
            send_random_stream();
    endtask

    task automatic test_random_traffic();
        int phase_idle  [4] = '{0, 45, 0, 10};
        int phase_stall [4] = '{0, 0, 45, 10};
        int target;
        for (int p = 0; p < 4; p++)
        begin
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            target    = random_items + RANDOM_ITEMS / 4;
            while (random_items < target)
                send_random_sequence();
            wait_drain();
        end
    endtask

    initial
    begin
        req.valid          = 1'b0;
        req.req_type       = REQ_KEY;
        req.key_byte       = '0;
        req.key_byte_valid = 1'b0;
        req.key_last       = 1'b0;
        req.byte_count     = '0;
        foreach (perm[n])
            perm[n] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_stream_after_reset();
        test_directed_keys();
        test_key_overflow();
        test_sender_pause();
        test_random_traffic();

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_ks.size() == 0)
            $display("PASS rc4_keystream_generator");
        else
            $display("FAIL rc4_keystream_generator");
        $finish;
    end

endmodule

// ----- sim.f -----
src/rc4_pkg.sv
src/rc4_req_if.sv
src/rc4_ks_if.sv
src/rc4_ctrl.sv
src/rc4_dp.sv
src/rc4_keystream_generator.sv
tb/rc4_keystream_generator_test.sv
